/* hdl/cartesian_to_polar_oriented_defines.svh */
// cartesian_to_polar_oriented_defines.svh: assertion macros shared by the
// cartesian_to_polar_oriented RTL. No dependencies.
`ifndef CARTESIAN_TO_POLAR_ORIENTED_DEFINES_SVH
`define CARTESIAN_TO_POLAR_ORIENTED_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define C2P_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every clock edge outside reset
`define C2P_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error(msg);

`endif

/* hdl/c2p_pkg.sv */
`timescale 1ns / 1ps
// c2p_pkg: widths, turn constants, arctangent table and latency helpers
// for the cartesian_to_polar_oriented block. No dependencies.
package c2p_pkg;

	localparam int COORD_BITS_DEF    = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int MODE_W  = 3;
	localparam int ANGLE_W = 16;
	localparam int DIST_W  = 24;

	// Orientation register bit positions
	localparam int MODE_NEG_X = 0;
	localparam int MODE_NEG_Y = 1;
	localparam int MODE_SWAP  = 2;

	// Rotation datapath: operands normalised so the larger has its MSB at bit 40
	localparam int NORM_MSB = 40;
	localparam int ROT_W    = 44;
	localparam int SH_W     = 6;

	// Angle accumulator in 2^-16 degree
	localparam int Z_W    = 26;
	localparam int TURN_W = 25;
	localparam int LUT_W  = 22;
	localparam int ANGLE_SHIFT = 9;

	localparam logic [TURN_W-1:0]  FULL_TURN   = 25'd23592960;
	localparam logic [TURN_W-1:0]  HALF_TURN   = 25'd11796480;
	localparam logic [TURN_W-1:0]  ROUND_HALF  = 25'd256;
	localparam logic [ANGLE_W-1:0] ANGLE_UNITS = 16'd46080;
	localparam logic [DIST_W-1:0]  DIST_MAX    = 24'hFFFFFF;

	// atan(2^-i) in 2^-16 degree, rounded to nearest
	function automatic logic [LUT_W-1:0] atan_lut(input logic [4:0] idx);
		logic [LUT_W-1:0] v;
		case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Register stages after the entry stage: magnitude, encode, shift,
	// rotations, wrap, round
	function automatic int angle_latency(input int stages);
		return stages + 5;
	endfunction

	// Register stages after the entry stage: squares, sum, root bits, round
	function automatic int dist_latency(input int coord_bits);
		return coord_bits + 3;
	endfunction

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* hdl/c2p_cordic.sv */
`timescale 1ns / 1ps
// c2p_cordic: normalising vectoring CORDIC pipeline giving the angle in
// 1/128 degree. Depends on c2p_pkg and cartesian_to_polar_oriented_defines.svh.
`include "cartesian_to_polar_oriented_defines.svh"

module c2p_cordic #(
	parameter int COORD_BITS    = c2p_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF,
	parameter int PAD           = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic signed [COORD_BITS:0]      in_a,
	input  logic signed [COORD_BITS:0]      in_b,
	input  logic                            in_half,
	output logic                            out_valid,
	output logic [c2p_pkg::ANGLE_W-1:0]     angle
);
	import c2p_pkg::*;

	localparam int OP_W   = COORD_BITS + 1;
	localparam int LEAD_W = $clog2(COORD_BITS);
	localparam int RND_W  = TURN_W + 1 - ANGLE_SHIFT;

	logic                       vld_s2, vld_s3;
	logic signed [OP_W-1:0]     a_s2, b_s2, a_s3, b_s3;
	logic                       half_s2, half_s3;
	logic [COORD_BITS-1:0]      top_s2;
	logic [SH_W-1:0]            sh_s3;

	logic signed [OP_W-1:0]     mag_a;
	logic [COORD_BITS-1:0]      top_next;
	logic [LEAD_W-1:0]          lead;

	logic signed [ROT_W-1:0]    rot_a_s [CORDIC_STAGES+1];
	logic signed [ROT_W-1:0]    rot_b_s [CORDIC_STAGES+1];
	logic signed [Z_W-1:0]      rot_z_s [CORDIC_STAGES+1];
	logic                       rot_half_s [CORDIC_STAGES+1];
	logic                       rot_vld_s [CORDIC_STAGES+1];

	logic                       turn_vld_s;
	logic [TURN_W-1:0]          turn_s;
	logic signed [Z_W-1:0]      zsum;
	logic [TURN_W-1:0]          turn_next;
	logic [TURN_W:0]            rsum;
	logic [RND_W-1:0]           rnd;

	logic [ANGLE_W-1:0]         ang_s [PAD+1];
	logic                       ang_vld_s [PAD+1];

	// Larger operand magnitude; b is already non-negative
	always_comb begin
		mag_a    = in_a[COORD_BITS] ? -in_a : in_a;
		top_next = (mag_a[COORD_BITS-1:0] > in_b[COORD_BITS-1:0]) ?
			mag_a[COORD_BITS-1:0] : in_b[COORD_BITS-1:0];
	end

	// Leading one of the larger magnitude
	always_comb begin
		lead = '0;
		for (int i = 0; i < COORD_BITS; i++) begin
			if (top_s2[i]) lead = LEAD_W'(i);
		end
	end

	// Advance the control bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			rot_vld_s[0] <= 1'b0;
		end else begin
			vld_s2       <= in_valid;
			vld_s3       <= vld_s2;
			rot_vld_s[0] <= vld_s3;
		end
	end

	// Front stages: magnitude, shift amount, normalising shift
	always_ff @(posedge clk) begin
		a_s2          <= in_a;
		b_s2          <= in_b;
		half_s2       <= in_half;
		top_s2        <= top_next;
		a_s3          <= a_s2;
		b_s3          <= b_s2;
		half_s3       <= half_s2;
		sh_s3         <= SH_W'(NORM_MSB) - SH_W'(lead);
		rot_a_s[0]    <= ROT_W'(a_s3) <<< sh_s3;
		rot_b_s[0]    <= ROT_W'(b_s3) <<< sh_s3;
		rot_z_s[0]    <= '0;
		rot_half_s[0] <= half_s3;
	end

	// One micro-rotation per stage, driving a towards zero
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		logic signed [ROT_W-1:0] da, db;
		logic signed [Z_W-1:0]   dz;

		assign da = rot_b_s[i] >>> i;
		assign db = rot_a_s[i] >>> i;
		assign dz = Z_W'(atan_lut(5'(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_vld_s[i+1] <= 1'b0;
			end else begin
				rot_vld_s[i+1] <= rot_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rot_half_s[i+1] <= rot_half_s[i];
			if (!rot_a_s[i][ROT_W-1]) begin
				rot_a_s[i+1] <= rot_a_s[i] - da;
				rot_b_s[i+1] <= rot_b_s[i] + db;
				rot_z_s[i+1] <= rot_z_s[i] + dz;
			end else begin
				rot_a_s[i+1] <= rot_a_s[i] + da;
				rot_b_s[i+1] <= rot_b_s[i] - db;
				rot_z_s[i+1] <= rot_z_s[i] - dz;
			end
		end
	end

	// Add the half turn and wrap a negative sum into one full turn
	always_comb begin
		zsum = rot_z_s[CORDIC_STAGES] +
			(rot_half_s[CORDIC_STAGES] ? Z_W'(HALF_TURN) : Z_W'(0));
		turn_next = zsum[Z_W-1] ? TURN_W'(zsum + Z_W'(FULL_TURN)) : TURN_W'(zsum);
	end

	// Round to 1/128 degree; a result of a full turn wraps to zero
	always_comb begin
		rsum = {1'b0, turn_s} + {1'b0, ROUND_HALF};
		rnd  = RND_W'(rsum >> ANGLE_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_vld_s   <= 1'b0;
			ang_vld_s[0] <= 1'b0;
		end else begin
			turn_vld_s   <= rot_vld_s[CORDIC_STAGES];
			ang_vld_s[0] <= turn_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		turn_s <= turn_next;
		if (rnd >= RND_W'(ANGLE_UNITS)) begin
			ang_s[0] <= '0;
		end else begin
			ang_s[0] <= rnd[ANGLE_W-1:0];
		end
	end

	// Delay to line up with the distance path
	for (genvar k = 0; k < PAD; k++) begin : g_pad
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ang_vld_s[k+1] <= 1'b0;
			end else begin
				ang_vld_s[k+1] <= ang_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			ang_s[k+1] <= ang_s[k];
		end
	end

	assign out_valid = ang_vld_s[PAD];
	assign angle     = ang_s[PAD];

	// Normalised operands must have their larger magnitude in [2^40, 2^41)
	logic [ROT_W-1:0] norm_mag_a, norm_b;
	logic             norm_ok;

	assign norm_mag_a = rot_a_s[0][ROT_W-1] ? ROT_W'(-rot_a_s[0]) : ROT_W'(rot_a_s[0]);
	assign norm_b     = ROT_W'(rot_b_s[0]);
	assign norm_ok    = ((norm_mag_a >> (NORM_MSB + 1)) == '0) &&
		((norm_b >> (NORM_MSB + 1)) == '0) &&
		(norm_mag_a[NORM_MSB] || norm_b[NORM_MSB]);

	`C2P_ASSERT_IMP(a_norm_range, clk, arst_n, rot_vld_s[0], norm_ok, "normalised operand out of range")
	`C2P_ASSERT_IMP(a_b_folded, clk, arst_n, in_valid, !in_b[COORD_BITS], "b operand not folded to the right half plane")

endmodule

/* hdl/c2p_isqrt.sv */
`timescale 1ns / 1ps
// c2p_isqrt: squares, sum and one-bit-per-stage integer square root with
// rounding and saturation. Depends on c2p_pkg and the defines header.
`include "cartesian_to_polar_oriented_defines.svh"

module c2p_isqrt #(
	parameter int COORD_BITS = c2p_pkg::COORD_BITS_DEF,
	parameter int PAD        = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [COORD_BITS-1:0]       mag_x,
	input  logic [COORD_BITS-1:0]       mag_y,
	output logic                        out_valid,
	output logic [c2p_pkg::DIST_W-1:0]  distance
);
	import c2p_pkg::*;

	localparam int SQ_W = 2 * COORD_BITS;
	localparam int RW   = COORD_BITS + 1;
	localparam int XW   = (RW > DIST_W) ? RW : DIST_W;

	logic                  vld_s2;
	logic [SQ_W-1:0]       sqx_s2, sqy_s2;

	logic [SQ_W-1:0]       rem_s [COORD_BITS+1];
	logic [COORD_BITS-1:0] root_s [COORD_BITS+1];
	logic                  root_vld_s [COORD_BITS+1];

	logic [RW-1:0]         rnd;
	logic [XW-1:0]         rnd_x;

	logic [DIST_W-1:0]     dist_s [PAD+1];
	logic                  dist_vld_s [PAD+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2        <= 1'b0;
			root_vld_s[0] <= 1'b0;
		end else begin
			vld_s2        <= in_valid;
			root_vld_s[0] <= vld_s2;
		end
	end

	// Square each magnitude, then sum into the root remainder
	always_ff @(posedge clk) begin
		sqx_s2    <= SQ_W'(mag_x) * SQ_W'(mag_x);
		sqy_s2    <= SQ_W'(mag_y) * SQ_W'(mag_y);
		rem_s[0]  <= sqx_s2 + sqy_s2;
		root_s[0] <= '0;
	end

	// Settle one root bit per stage, most significant first
	for (genvar j = 0; j < COORD_BITS; j++) begin : g_root
		localparam int K = COORD_BITS - 1 - j;
		logic [SQ_W-1:0] trial;

		assign trial = (SQ_W'(root_s[j]) << (K + 1)) | (SQ_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_vld_s[j+1] <= 1'b0;
			end else begin
				root_vld_s[j+1] <= root_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[j] >= trial) begin
				rem_s[j+1]  <= rem_s[j] - trial;
				root_s[j+1] <= root_s[j] | (COORD_BITS'(1) << K);
			end else begin
				rem_s[j+1]  <= rem_s[j];
				root_s[j+1] <= root_s[j];
			end
		end
	end

	// Round to nearest and clamp to the output range
	always_comb begin
		rnd = (SQ_W'(root_s[COORD_BITS]) < rem_s[COORD_BITS]) ?
			RW'(root_s[COORD_BITS]) + RW'(1) : RW'(root_s[COORD_BITS]);
		rnd_x = XW'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_vld_s[0] <= 1'b0;
		end else begin
			dist_vld_s[0] <= root_vld_s[COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_x > XW'(DIST_MAX)) begin
			dist_s[0] <= DIST_MAX;
		end else begin
			dist_s[0] <= rnd_x[DIST_W-1:0];
		end
	end

	// Delay to line up with the angle path
	for (genvar k = 0; k < PAD; k++) begin : g_pad
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dist_vld_s[k+1] <= 1'b0;
			end else begin
				dist_vld_s[k+1] <= dist_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dist_s[k+1] <= dist_s[k];
		end
	end

	assign out_valid = dist_vld_s[PAD];
	assign distance  = dist_s[PAD];

	// Floor root leaves a remainder no larger than twice the root
	`C2P_ASSERT_IMP(a_root_rem, clk, arst_n, root_vld_s[COORD_BITS], rem_s[COORD_BITS] <= (SQ_W'(root_s[COORD_BITS]) << 1), "square root remainder too large")

endmodule

/* hdl/cartesian_to_polar_oriented.sv */
`timescale 1ns / 1ps
// cartesian_to_polar_oriented: top level, orientation register and entry
// stage. Depends on c2p_pkg, c2p_cordic, c2p_isqrt and the defines header.
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------
//  point     start / busy          x_coord, y_coord
//  config    polar_mode_we         polar_mode_wdata
//  result    done (strobe)         angle, distance
//
// One point is taken every clock; busy stays low.
// The result transfers after the entry stage and the longer of the angle and
// distance paths, the shorter one padded to match; at default sizes the COORD_BITS
// root-bit stages make the distance path the longer, the CORDIC being the shorter path.
// Reset clears the valid bits and polar_mode; there is no clearing pass.
// The receiver cannot stall, so the pipe never holds.
`include "cartesian_to_polar_oriented_defines.svh"

module cartesian_to_polar_oriented #(
	parameter int COORD_BITS    = c2p_pkg::COORD_BITS_DEF,
	parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [COORD_BITS-1:0]       x_coord,
	input  logic signed [COORD_BITS-1:0]       y_coord,
	input  logic                               polar_mode_we,
	input  logic [c2p_pkg::MODE_W-1:0]         polar_mode_wdata,
	output logic                               done,
	output logic [c2p_pkg::ANGLE_W-1:0]        angle,
	output logic [c2p_pkg::DIST_W-1:0]         distance
);
	import c2p_pkg::*;

	localparam int ANG_LAT  = angle_latency(CORDIC_STAGES);
	localparam int DST_LAT  = dist_latency(COORD_BITS);
	localparam int PIPE_LAT = max_int(ANG_LAT, DST_LAT);
	localparam int OP_W     = COORD_BITS + 1;

	logic [MODE_W-1:0]      polar_mode_q;
	logic                   accept;

	logic                   vld_s1;
	logic signed [OP_W-1:0] op_a_s1, op_b_s1;
	logic                   half_s1;
	logic [COORD_BITS-1:0]  mag_x_s1, mag_y_s1;

	logic signed [OP_W-1:0] xe, ye, yo, ax, ay, sa, sb, na, nb;
	logic                   half;
	logic [COORD_BITS-1:0]  mx, my;

	logic                   dist_vld;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Hold the orientation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_mode_q <= '0;
		end else if (polar_mode_we) begin
			polar_mode_q <= polar_mode_wdata;
		end
	end

	// Orient the point and fold it into the right half plane
	always_comb begin
		xe = OP_W'(x_coord);
		ye = OP_W'(y_coord);
		mx = xe[OP_W-1] ? COORD_BITS'(-xe) : COORD_BITS'(xe);
		my = ye[OP_W-1] ? COORD_BITS'(-ye) : COORD_BITS'(ye);
		// origin takes the angle of the +Y axis
		yo = ((x_coord == '0) && (y_coord == '0)) ? OP_W'(1) : ye;
		ax = polar_mode_q[MODE_NEG_X] ? -xe : xe;
		ay = polar_mode_q[MODE_NEG_Y] ? -yo : yo;
		sa = polar_mode_q[MODE_SWAP] ? ay : ax;
		sb = polar_mode_q[MODE_SWAP] ? ax : ay;
		half = sb[OP_W-1];
		na = half ? -sa : sa;
		nb = half ? -sb : sb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_a_s1  <= na;
		op_b_s1  <= nb;
		half_s1  <= half;
		mag_x_s1 <= mx;
		mag_y_s1 <= my;
	end

	c2p_cordic #(
		.COORD_BITS    (COORD_BITS),
		.CORDIC_STAGES (CORDIC_STAGES),
		.PAD           (PIPE_LAT - ANG_LAT)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_a      (op_a_s1),
		.in_b      (op_b_s1),
		.in_half   (half_s1),
		.out_valid (done),
		.angle     (angle)
	);

	c2p_isqrt #(
		.COORD_BITS (COORD_BITS),
		.PAD        (PIPE_LAT - DST_LAT)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.mag_x     (mag_x_s1),
		.mag_y     (mag_y_s1),
		.out_valid (dist_vld),
		.distance  (distance)
	);

	// Both paths must deliver the same transfer in the same cycle
	`C2P_ASSERT_ALWAYS(a_paths_aligned, clk, arst_n, dist_vld == done, "angle and distance paths out of step")
	`C2P_ASSERT_IMP(a_angle_range, clk, arst_n, done, angle < ANGLE_UNITS, "angle at or above a full turn")

endmodule

/* tb/tb_cartesian_to_polar_oriented.sv */
`timescale 1ns / 1ps
// tb_cartesian_to_polar_oriented: self-checking bench for the oriented cartesian to
// polar converter. Depends on c2p_pkg and the cartesian_to_polar_oriented RTL.
module tb_cartesian_to_polar_oriented;

	localparam int CW         = 24;
	localparam int PIPE_LAT   = 28;	// accepting edge to result transfer at default sizes
	localparam int QUIET_MAX  = 2000;
	localparam int PHASE_ITEMS = 200;

	localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

	// Predicts angle and distance for each transferred point and checks results in order
	class polar_scoreboard;
		typedef struct {
			logic [c2p_pkg::ANGLE_W-1:0] ang;
			logic [c2p_pkg::DIST_W-1:0]  dst;
		} polar_t;

		localparam int STAGES = 16;
		localparam longint FULL_Q16 = 64'd23592960;
		localparam longint HALF_Q16 = 64'd11796480;
		localparam longint NORM_FLOOR = 64'd1 << 40;

		polar_t expected_q[$];
		logic [c2p_pkg::MODE_W-1:0] mode;
		longint atan_q16[STAGES];
		int errors;

		function new();
			mode = '0;
			errors = 0;
			atan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
				14668, 7334, 3667, 1833, 917, 458, 229, 115};
		endfunction

		function void set_mode(logic [c2p_pkg::MODE_W-1:0] m);
			mode = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Rounded integer square root of a sum of squares below 2^48
		function logic [c2p_pkg::DIST_W-1:0] rounded_root(longint n);
			longint r, t;
			r = 0;
			for (int b = 24; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n)
					r = t;
			end
			if (n - r * r > r)
				r = r + 1;
			if (r > 64'hFFFFFF)
				r = 64'hFFFFFF;
			return r[c2p_pkg::DIST_W-1:0];
		endfunction

		// Vectoring rotation on normalised operands; angle in 1/128 degree
		function logic [c2p_pkg::ANGLE_W-1:0] vector_angle(longint a, longint b);
			longint base, z, da, db, total;
			longint unsigned m;
			int s;
			base = 0;
			z = 0;
			s = 0;
			if (b < 0) begin
				a = -a;
				b = -b;
				base = HALF_Q16;
			end
			m = ((a < 0) ? -a : a) > ((b < 0) ? -b : b) ? ((a < 0) ? -a : a) :
				((b < 0) ? -b : b);
			while ((m << s) < NORM_FLOOR)
				s++;
			a = a * (longint'(1) << s);
			b = b * (longint'(1) << s);
			for (int i = 0; i < STAGES; i++) begin
				da = b >>> i;
				db = a >>> i;
				if (a >= 0) begin
					a = a - da;
					b = b + db;
					z = z + atan_q16[i];
				end else begin
					a = a + da;
					b = b - db;
					z = z - atan_q16[i];
				end
			end
			total = (base + FULL_Q16 + z) % FULL_Q16;
			total = (total + 256) >>> 9;
			if (total >= 46080)
				total = 0;
			return total[c2p_pkg::ANGLE_W-1:0];
		endfunction

		function polar_t polar_of(logic signed [CW-1:0] xi, logic signed [CW-1:0] yi);
			polar_t p;
			longint x, y, a, b;
			x = xi;
			y = yi;
			p.dst = rounded_root(x * x + y * y);
			// origin takes the direction of the +Y axis
			if (x == 0 && y == 0)
				y = 1;
			if (mode[c2p_pkg::MODE_NEG_X])
				x = -x;
			if (mode[c2p_pkg::MODE_NEG_Y])
				y = -y;
			if (mode[c2p_pkg::MODE_SWAP]) begin
				a = y;
				b = x;
			end else begin
				a = x;
				b = y;
			end
			p.ang = vector_angle(a, b);
			return p;
		endfunction

		function void note_point(logic signed [CW-1:0] xi, logic signed [CW-1:0] yi);
			expected_q.push_back(polar_of(xi, yi));
		endfunction

		task report_mismatch(string what, longint got, longint want);
			errors++;
			if (errors <= 40)
				$display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		endtask

		task check_result(logic [c2p_pkg::ANGLE_W-1:0] ang, logic [c2p_pkg::DIST_W-1:0] dst);
			polar_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result angle", ang, -1);
			end else begin
				want = expected_q.pop_front();
				if (ang !== want.ang)
					report_mismatch("angle", ang, want.ang);
				if (dst !== want.dst)
					report_mismatch("distance", dst, want.dst);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [CW-1:0] x_coord;
	logic signed [CW-1:0] y_coord;
	logic polar_mode_we;
	logic [c2p_pkg::MODE_W-1:0] polar_mode_wdata;
	logic done;
	logic [c2p_pkg::ANGLE_W-1:0] angle;
	logic [c2p_pkg::DIST_W-1:0] distance;

	polar_scoreboard sb;
	int quiet_cycles;

	cartesian_to_polar_oriented u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.x_coord          (x_coord),
		.y_coord          (y_coord),
		.polar_mode_we    (polar_mode_we),
		.polar_mode_wdata (polar_mode_wdata),
		.done             (done),
		.angle            (angle),
		.distance         (distance)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Observe transfers: check results first, then note new points and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(angle, distance);
			if (start && !busy)
				sb.note_point(x_coord, y_coord);
			if (polar_mode_we)
				sb.set_mode(polar_mode_wdata);
		end
	end

	// Watchdog: abort when nothing transfers for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done || polar_mode_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("cartesian_to_polar_oriented verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one point and hold it until the block takes it
	task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
		start <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop start and wait for every outstanding result, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	task automatic write_mode(input logic [c2p_pkg::MODE_W-1:0] m);
		polar_mode_we <= 1'b1;
		polar_mode_wdata <= m;
		@(posedge clk);
		polar_mode_we <= 1'b0;
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		logic signed [CW-1:0] v;
		v = CW'($urandom());
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4: v = CW'($signed($urandom_range(0, 8)) - 4);
			5: case ($urandom_range(0, 4))
				0: v = C_MAX;
				1: v = C_MIN;
				2: v = -C_MAX;
				3: v = '0;
				default: v = C_MAX - 24'sd1;
			endcase
			6: v = CW'($signed($urandom_range(0, 2047)) - 1024);
			default: v = v >>> $urandom_range(0, 22);
		endcase
		return v;
	endfunction

	// Random points in bursts; shapes cover origin, axes, diagonals and general points
	task automatic random_phase(input int n, input bit gapless);
		logic signed [CW-1:0] x, y;
		int sent, burst, gap;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				if (sent < n) begin
					x = pick_coord();
					y = pick_coord();
					case ($urandom_range(0, 9))
						0: begin x = 0; y = 0; end
						1: if ($urandom_range(0, 1)) x = 0; else y = 0;
						2: y = $urandom_range(0, 1) ? x : -x;
						default: ;
					endcase
					send_point(x, y);
					sent++;
				end
			end
			gap = ($urandom_range(0, 3) == 0 || gapless) ? 0 : $urandom_range(1, 12);
			if (gap != 0)
				idle_cycles(gap);
		end
	endtask

	initial begin
		logic [c2p_pkg::MODE_W-1:0] order[10];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		polar_mode_we = 1'b0;
		polar_mode_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points under the reset orientation
		send_point(0, 0);
		send_point(C_MAX, C_MAX);
		send_point(C_MIN, C_MIN);
		send_point(C_MIN, C_MAX);
		send_point(C_MAX, C_MIN);
		send_point(0, C_MIN);
		send_point(C_MIN, 0);
		send_point(0, C_MAX);
		send_point(C_MAX, 0);
		send_point(1, 0);
		send_point(0, 1);
		send_point(-1, 0);
		send_point(0, -1);
		send_point(1, 1);
		send_point(-1, -1);
		send_point(-1, C_MAX);	// just short of a full turn, rounds up to zero
		send_point(0, -5);	// straight behind: half turn
		send_point(-C_MAX, 1);
		send_point(3, -4);
		send_point(24'sh555555, 24'shAAAAAA);
		idle_cycles(3);
		send_point(24'shAAAAAA, 24'sh555555);
		drain();

		random_phase(PHASE_ITEMS, 1'b0);

		// Walk every orientation, the extremes among them, with a pause before each write
		order = '{3'd7, 3'd3, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4, 3'd0, 3'd7, 3'd0};
		order[9] = c2p_pkg::MODE_W'($urandom_range(0, 7));
		foreach (order[p]) begin
			drain();
			write_mode(order[p]);
			send_point(0, 0);
			send_point(C_MIN, C_MAX);
			random_phase(PHASE_ITEMS, (p % 3) == 0);
		end

		drain();
		if (sb.pending() != 0)
			sb.report_mismatch("results outstanding", 0, sb.pending());
		if (sb.errors == 0)
			$display("cartesian_to_polar_oriented verification clean");
		else
			$display("cartesian_to_polar_oriented verification failed");
		$finish;
	end

endmodule
